### design/dcps_pkg.sv
package dcps_pkg;

  localparam int SampleWidth = 24;
  localparam int DiffW       = SampleWidth + 1;
  localparam int MulAW       = 17;
  localparam int MulBW       = 33;
  localparam int ProdW       = MulAW + MulBW;
  localparam int AccW        = ProdW + 2;
  localparam int StepW       = 3;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 31;

  localparam logic [StepW-1:0] StepWait = StepW'(0);
  localparam logic [StepW-1:0] StepMulErr = StepW'(1);
  localparam logic [StepW-1:0] StepErr = StepW'(2);
  localparam logic [StepW-1:0] StepUpd = StepW'(3);
  localparam logic [StepW-1:0] StepMulI = StepW'(4);
  localparam logic [StepW-1:0] StepMulD = StepW'(5);
  localparam logic [StepW-1:0] StepAcc = StepW'(6);
  localparam logic [StepW-1:0] StepOut = StepW'(7);

  typedef enum logic [CfgIdxW-1:0] {
    REG_ERROR_SCALE    = 3'd0,
    REG_PROP_GAIN      = 3'd1,
    REG_INTEG_GAIN     = 3'd2,
    REG_DERIV_GAIN     = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_ERR = 2'd0,
    MUL_P   = 2'd1,
    MUL_I   = 2'd2,
    MUL_D   = 2'd3
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_SET  = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [1:0] {
    COND_NONE        = 2'd0,
    COND_NO_ITEM     = 2'd1,
    COND_OUT_BLOCKED = 2'd2
  } cond_e;

  typedef struct packed {
    logic                    side;
    logic signed [SampleWidth-1:0] speed_target;
    logic signed [SampleWidth-1:0] speed_measured;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic [31:0]        odometry_total;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        error_scale;
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic [30:0]        integral_limit;
  } cfg_t;

  typedef struct packed {
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             load;
    logic             mul_en;
    mul_sel_e         mul_sel;
    logic             err_ld;
    logic             upd;
    acc_op_e          acc_op;
    logic             out_ld;
  } ucode_t;

  typedef struct packed {
    logic     ready;
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     err_ld;
    logic     upd;
    acc_op_e  acc_op;
    logic     out_ld;
  } ctrl_t;

  typedef struct packed {
    logic item_valid;
    logic out_blocked;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic [AccW-32:0] upper;
    upper = v[AccW-1:31];
    if ((&upper) || !(|upper)) begin
      return v[31:0];
    end
    return v[AccW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

### design/dcps_sequencer.sv
module dcps_sequencer
  import dcps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [StepW-1:0] step_q, step_d;
  ucode_t           uc;
  logic             jump;

  function automatic ucode_t rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '0;
    w.cond = COND_NONE;
    w.mul_sel = MUL_ERR;
    w.acc_op = ACC_HOLD;
    unique case (step)
      StepWait: begin
        w.cond = COND_NO_ITEM;
        w.target = StepWait;
        w.load = 1'b1;
      end
      StepMulErr: begin
        w.mul_en = 1'b1;
        w.mul_sel = MUL_ERR;
      end
      StepErr: begin
        w.err_ld = 1'b1;
      end
      StepUpd: begin
        w.upd = 1'b1;
        w.mul_en = 1'b1;
        w.mul_sel = MUL_P;
      end
      StepMulI: begin
        w.mul_en = 1'b1;
        w.mul_sel = MUL_I;
        w.acc_op = ACC_SET;
      end
      StepMulD: begin
        w.mul_en = 1'b1;
        w.mul_sel = MUL_D;
        w.acc_op = ACC_ADD;
      end
      StepAcc: begin
        w.acc_op = ACC_ADD;
      end
      StepOut: begin
        w.cond = COND_OUT_BLOCKED;
        w.target = StepOut;
        w.out_ld = 1'b1;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    uc = rom(step_q);
    unique case (uc.cond)
      COND_NONE:        jump = 1'b0;
      COND_NO_ITEM:     jump = !status_i.item_valid;
      COND_OUT_BLOCKED: jump = status_i.out_blocked;
      default:          jump = 1'b0;
    endcase
    step_d = jump ? uc.target : step_q + StepW'(1);

    ctrl_o.ready   = (step_q == StepWait);
    ctrl_o.load    = uc.load & !jump;
    ctrl_o.mul_en  = uc.mul_en & !jump;
    ctrl_o.mul_sel = uc.mul_sel;
    ctrl_o.err_ld  = uc.err_ld & !jump;
    ctrl_o.upd     = uc.upd & !jump;
    ctrl_o.acc_op  = jump ? ACC_HOLD : uc.acc_op;
    ctrl_o.out_ld  = uc.out_ld & !jump;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepWait;
    end else begin
      step_q <= step_d;
    end
  end

  a_out_returns_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_ld |=> (step_q == StepWait))
    else $error("sequencer did not return to wait after result load");

endmodule

### design/dcps_datapath.sv
module dcps_datapath
  import dcps_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  in_item_t           in_item_i,
  input  cfg_t               cfg_i,
  output logic signed [31:0] drive_o,
  output logic [31:0]        odometry_o
);

  localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [31:0] integ_mem [CHANNELS];
  logic signed [31:0] prev_mem  [CHANNELS];
  logic [31:0]        odo_mem   [CHANNELS];

  logic [ChW-1:0]          ch_in, ch_q;
  logic signed [DiffW-1:0] diff_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [31:0]      e32_q, integ_q;
  logic signed [MulBW-1:0] deriv_q;
  logic signed [AccW-1:0]  acc_q;
  logic [31:0]             odo_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [AccW-1:0]  prod_x, err_b, err_s, drv_b, drv_s;
  logic signed [31:0]      e32_d, isat, inext, limit_s;
  logic signed [32:0]      isum;
  logic [31:0]             odo_d;

  always_comb begin
    if (int'(in_item_i.side) >= CHANNELS) begin
      ch_in = ChW'(CHANNELS - 1);
    end else begin
      ch_in = ChW'(in_item_i.side);
    end
    odo_d = odo_mem[ch_in] + 32'(in_item_i.speed_measured);

    case (ctrl_i.mul_sel)
      MUL_ERR: begin
        mul_a = $signed({1'b0, cfg_i.error_scale});
        mul_b = MulBW'(diff_q);
      end
      MUL_P: begin
        mul_a = MulAW'(cfg_i.prop_gain);
        mul_b = MulBW'(e32_q);
      end
      MUL_I: begin
        mul_a = MulAW'(cfg_i.integ_gain);
        mul_b = MulBW'(integ_q);
      end
      default: begin
        mul_a = MulAW'(cfg_i.deriv_gain);
        mul_b = deriv_q;
      end
    endcase
    mul_p = mul_a * mul_b;

    prod_x = AccW'(prod_q);
    err_b  = prod_x + (prod_x[AccW-1] ? AccW'(16'hFFFF) : AccW'(0));
    err_s  = err_b >>> 16;
    e32_d  = sat32(err_s);

    isum    = 33'(integ_mem[ch_q]) + 33'(e32_q);
    isat    = sat32(AccW'(isum));
    limit_s = $signed({1'b0, cfg_i.integral_limit});
    inext   = (isat > limit_s) ? limit_s : isat;

    drv_b = acc_q + (acc_q[AccW-1] ? AccW'(8'hFF) : AccW'(0));
    drv_s = drv_b >>> 8;
  end

  assign drive_o    = sat32(drv_s);
  assign odometry_o = odo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integ_mem[i] <= '0;
        prev_mem[i]  <= '0;
        odo_mem[i]   <= '0;
      end
    end else begin
      if (ctrl_i.load) begin
        odo_mem[ch_in] <= odo_d;
      end
      if (ctrl_i.upd) begin
        integ_mem[ch_q] <= inext;
        prev_mem[ch_q]  <= e32_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ch_q   <= ch_in;
      diff_q <= DiffW'(in_item_i.speed_target) - DiffW'(in_item_i.speed_measured);
      odo_q  <= odo_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (ctrl_i.err_ld) begin
      e32_q <= e32_d;
    end
    if (ctrl_i.upd) begin
      integ_q <= inext;
      deriv_q <= MulBW'(e32_q) - MulBW'(prev_mem[ch_q]);
    end
    case (ctrl_i.acc_op)
      ACC_SET: acc_q <= AccW'(prod_q);
      ACC_ADD: acc_q <= acc_q + AccW'(prod_q);
      default: acc_q <= acc_q;
    endcase
  end

  a_integ_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.upd |=> (integ_q <= $signed({1'b0, cfg_i.integral_limit})))
    else $error("integral above its limit after update");

endmodule

### design/dual_channel_pid_speed.sv
// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   in_item_i  (side, speed_target, speed_measured)
// out       out_valid_o / out_stall_i out_item_o (drive, odometry_total)
// cfg       cfg_we_i                  cfg_index_i, cfg_data_i
//
// An item is carried from acceptance to the result register before another is accepted:
// the microprogram runs the one shared 17x33 multiplier four times, plus error, update and
// sum steps. A new item can be accepted in the cycle after the result is loaded.
// Reset loads the register defaults and zeroes integral, last error and odometry.
// A stalled result holds the last step until the output register is free.
module dual_channel_pid_speed
  import dcps_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t               cfg_q;
  ctrl_t              ctrl;
  status_t            status;
  logic               out_valid_q;
  out_item_t          out_q;
  logic signed [31:0] drive;
  logic [31:0]        odometry;

  assign status.item_valid  = in_valid_i;
  assign status.out_blocked = out_valid_q & out_stall_i;
  assign in_stall_o  = !ctrl.ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  dcps_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  dcps_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .drive_o    (drive),
    .odometry_o (odometry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.error_scale    <= 16'd6554;
      cfg_q.prop_gain      <= 16'sd256;
      cfg_q.integ_gain     <= '0;
      cfg_q.deriv_gain     <= '0;
      cfg_q.integral_limit <= 31'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ERROR_SCALE:    cfg_q.error_scale    <= cfg_data_i[15:0];
        REG_PROP_GAIN:      cfg_q.prop_gain      <= cfg_data_i[15:0];
        REG_INTEG_GAIN:     cfg_q.integ_gain     <= cfg_data_i[15:0];
        REG_DERIV_GAIN:     cfg_q.deriv_gain     <= cfg_data_i[15:0];
        REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      out_q.drive          <= drive;
      out_q.odometry_total <= odometry;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_ld |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_result_follows_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_ld |=> out_valid_o)
    else $error("result not presented after load");

endmodule

### tb/tb_top.sv
module tb_top
  import dcps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Sides = 2;
  localparam int SampleMax = (1 << (SampleWidth - 1)) - 1;
  localparam int SampleMin = -(1 << (SampleWidth - 1));
  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;
  localparam int WatchdogLimit = 3000;
  localparam int RandomItemsPerSetting = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cfg_t pid_cfg = '{
    error_scale: 16'd6554,
    prop_gain: 16'sd256,
    integ_gain: 16'sd0,
    deriv_gain: 16'sd0,
    integral_limit: 31'h7FFF_FFFF
  };
  logic signed [31:0] integ_acc [Sides] = '{default: '0};
  logic signed [31:0] last_error [Sides] = '{default: '0};
  logic [31:0]        odo_total [Sides] = '{default: '0};

  out_item_t drive_q [$];
  int fail_count = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  logic run_side = 1'b0;

  dual_channel_pid_speed dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint div_pow2(longint v, int s);
    if (v < 0) begin
      return -((-v) >> s);
    end
    return v >> s;
  endfunction

  function automatic logic signed [31:0] saturate_word(longint v);
    if (v > WordMax) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < WordMin) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t compute_drive(in_item_t it);
    longint meas, diff, scale, lim, integ, deriv, acc;
    logic signed [31:0] e32;
    out_item_t res;
    meas = $signed(it.speed_measured);
    diff = longint'($signed(it.speed_target)) - meas;
    scale = pid_cfg.error_scale;
    lim = pid_cfg.integral_limit;
    odo_total[it.side] = odo_total[it.side] + meas[31:0];
    e32 = saturate_word(div_pow2(diff * scale, 16));
    integ = saturate_word(longint'(integ_acc[it.side]) + longint'(e32));
    if (integ > lim) begin
      integ = lim;
    end
    integ_acc[it.side] = integ[31:0];
    deriv = longint'(e32) - longint'(last_error[it.side]);
    last_error[it.side] = e32;
    acc = longint'(pid_cfg.prop_gain) * longint'(e32)
        + longint'(pid_cfg.integ_gain) * integ
        + longint'(pid_cfg.deriv_gain) * deriv;
    res.drive = saturate_word(div_pow2(acc, 8));
    res.odometry_total = odo_total[it.side];
    return res;
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          $display("%0t unexpected item: drive %0d, odometry %0d", $time,
                   out_item_o.drive, out_item_o.odometry_total);
          fail_count++;
        end else begin
          want = drive_q.pop_front();
          if (out_item_o.drive !== want.drive) begin
            $display("%0t drive mismatch: expected %0d, actual %0d", $time,
                     want.drive, out_item_o.drive);
            fail_count++;
          end
          if (out_item_o.odometry_total !== want.odometry_total) begin
            $display("%0t odometry mismatch: expected %0d, actual %0d", $time,
                     want.odometry_total, out_item_o.odometry_total);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        drive_q.push_back(compute_drive(in_item_i));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic in_item_t make_item(logic s, int t, int m);
    in_item_t it;
    it.side = s;
    it.speed_target = SampleWidth'(t);
    it.speed_measured = SampleWidth'(m);
    return it;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(7))
      0: return SampleMax;
      1: return SampleMin;
      2, 3: return int'($urandom_range(200)) - 100;
      default: return int'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(512)) - 16'd256;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(3))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(1 << 20));
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_q.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_ERROR_SCALE: pid_cfg.error_scale = data[15:0];
      REG_PROP_GAIN: pid_cfg.prop_gain = data[15:0];
      REG_INTEG_GAIN: pid_cfg.integ_gain = data[15:0];
      REG_DERIV_GAIN: pid_cfg.deriv_gain = data[15:0];
      REG_INTEGRAL_LIMIT: pid_cfg.integral_limit = data[30:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [15:0] scale, input logic [15:0] pg,
                           input logic [15:0] ig, input logic [15:0] dg,
                           input logic [30:0] lim);
    write_reg(REG_ERROR_SCALE, {15'd0, scale});
    write_reg(REG_PROP_GAIN, {15'd0, pg});
    write_reg(REG_INTEG_GAIN, {15'd0, ig});
    write_reg(REG_DERIV_GAIN, {15'd0, dg});
    write_reg(REG_INTEGRAL_LIMIT, lim);
  endtask

  task automatic test_reset_defaults();
    send_item(make_item(1'b0, 0, 0));
    send_item(make_item(1'b1, 0, 0));
    send_item(make_item(1'b0, SampleMax, SampleMin));
    send_item(make_item(1'b1, SampleMin, SampleMax));
    send_item(make_item(1'b0, SampleMax, SampleMax));
    send_item(make_item(1'b1, SampleMin, SampleMin));
    send_item(make_item(1'b0, 1, 0));
    send_item(make_item(1'b1, -1, 0));
    send_item(make_item(1'b0, 0, SampleMin));
    send_item(make_item(1'b1, 100, 37));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_all(16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF);
    send_item(make_item(1'b0, SampleMax, SampleMin));
    send_item(make_item(1'b1, SampleMin, SampleMax));
    send_item(make_item(1'b0, 5, 3));
    send_item(make_item(1'b1, 0, 0));
    wait_idle();
    write_all(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 31'd0);
    send_item(make_item(1'b0, SampleMax, SampleMin));
    send_item(make_item(1'b1, SampleMin, SampleMax));
    send_item(make_item(1'b0, SampleMin, SampleMax));
    send_item(make_item(1'b1, 1000, -1000));
    wait_idle();
    write_all(16'h0001, 16'h7FFF, 16'h8000, 16'h7FFF, 31'h7FFF_FFFF);
    send_item(make_item(1'b0, SampleMax, SampleMin));
    send_item(make_item(1'b1, SampleMin, SampleMax));
    send_item(make_item(1'b0, -65536, 0));
    send_item(make_item(1'b1, 65535, 0));
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_all(16'd6554, 16'd256, 16'd64, 16'd32, 31'd100000);
    for (int i = REG_INTEGRAL_LIMIT + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), CfgDataW'($urandom()));
    end
    repeat (4) send_item(make_item(1'($urandom()), rand_sample(), rand_sample()));
  endtask

  task automatic test_integral_saturation();
    wait_idle();
    write_all(16'hFFFF, 16'h0100, 16'h7FFF, 16'h0040, 31'h7FFF_FFFF);
    repeat (140) begin
      send_item(make_item(1'b0, SampleMin, SampleMax));
      send_item(make_item(1'b1, SampleMax, SampleMin));
    end
    wait_idle();
    write_reg(REG_INTEGRAL_LIMIT, 31'd1000000);
    repeat (3) send_item(make_item(1'b1, SampleMax, 0));
    repeat (3) send_item(make_item(1'b1, SampleMin, 0));
    repeat (3) send_item(make_item(1'b0, SampleMax, SampleMin));
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_all(16'd6554, 16'd512, 16'd16, 16'hFF00, 31'd5000000);
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    repeat (16) send_item(make_item(1'($urandom()), rand_sample(), rand_sample()));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 47; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 47; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        wait_idle();
        write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_limit());
        repeat (RandomItemsPerSetting) begin
          if ($urandom_range(9) == 0) begin
            run_side = ~run_side;
          end
          send_item(make_item(run_side, rand_sample(), rand_sample()));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_unused_index();
    test_integral_saturation();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
